[design/output_descriptor_checksum_core_assert.svh]
// Assertion macros used by the checker file odc_checker.
// No dependencies; include by bare file name.
`ifndef OUTPUT_DESCRIPTOR_CHECKSUM_CORE_ASSERT_SVH
`define OUTPUT_DESCRIPTOR_CHECKSUM_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ODC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odc assertion failed (same cycle)");

// Next-cycle implication, disabled during reset.
`define ODC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odc assertion failed (next cycle)");

`endif

[design/odc_pkg.sv]
// Shared types, constants and functions of the descriptor checksum core.
// No dependencies; imported by the top level, the absorber and the finisher.
package odc_pkg;

  localparam int IN_COUNT  = 95;
  localparam int OUT_COUNT = 32;
  localparam int SYM_COUNT = 8;

  // Input charset, first character in the top byte.
  localparam logic [IN_COUNT*8-1:0] IN_SET = {
    "0123456789()[],'/*abcdefgh@:$%{}IJKLMNOPQRSTUVWXYZ&+-.;<=>?!^_|~ijklmnopqrstuvwxyzABCDEFGH",
    8'h60, 8'h23, 8'h22, 8'h5C, 8'h20
  };

  localparam logic [OUT_COUNT*8-1:0] OUT_SET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  localparam logic [39:0] GEN [5] = '{
    40'hf5dee51989, 40'ha9fdca3312, 40'h1bab10e32d, 40'h3706b1677a, 40'h644d626ffd
  };

  // Lookup entry: bit 7 marks a known character, bits 6:0 give its index.
  typedef logic [7:0] lut_t [256];

  function automatic lut_t build_in_lut();
    lut_t t;
    int   i;
    for (i = 0; i < 256; i++) t[i] = '0;
    for (i = 0; i < IN_COUNT; i++) begin
      t[IN_SET[(IN_COUNT-1-i)*8 +: 8]] = {1'b1, 7'(i)};
    end
    return t;
  endfunction

  localparam lut_t IN_LUT = build_in_lut();

  // One polymod step: shift in a 5-bit symbol, fold the top five bits back.
  function automatic logic [39:0] poly_step(logic [39:0] s, logic [4:0] sym);
    logic [39:0] n;
    int          i;
    n = {s[34:0], sym};
    for (i = 0; i < 5; i++) begin
      if (s[35+i]) n = n ^ GEN[i];
    end
    return n;
  endfunction

  function automatic logic [7:0] out_char(logic [4:0] sym);
    int k;
    k = OUT_COUNT - 1 - int'(sym);
    return OUT_SET[k*8 +: 8];
  endfunction

  // Work handed from the absorber to the finisher at end of string.
  typedef struct packed {
    logic [39:0] poly;
    logic [4:0]  accum;
    logic        flush;
    logic        bad;
  } odc_job_t;

  typedef enum logic [1:0] {
    FIN_IDLE,
    FIN_FLUSH,
    FIN_ZERO,
    FIN_EMIT
  } fin_state_t;

endpackage

[design/odc_if.sv]
// Valid/ready channel interfaces for the descriptor checksum core.
// No dependencies.
interface odc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       end_of_string;

  modport source (output valid, char_code, has_char, end_of_string, input ready);
  modport sink   (input valid, char_code, has_char, end_of_string, output ready);
endinterface

interface odc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] checksum_char;
  logic       status;
  logic       final_char;

  modport source (output valid, checksum_char, status, final_char, input ready);
  modport sink   (input valid, checksum_char, status, final_char, output ready);
endinterface

[design/output_descriptor_checksum_core.sv]
// Top level of the descriptor checksum core (BIP380 style, 40-bit polymod).
// Depends on odc_pkg, odc_if, odc_absorb and odc_finish.
//
//   channel  | role   | payload                                   | moves per item
//   in_ch    | sink   | char_code[7:0], has_char, end_of_string   | one character
//   out_ch   | source | checksum_char[7:0], status, final_char    | one checksum char
//
// Cycles: one input item per cycle while in_ch is not stalled. An end-of-string
//   item is handed to the finisher, which takes the run, applies the partial
//   class symbol if one is pending, runs eight zero steps and loads the output
//   register; the checksum items then follow one per cycle while the output is
//   not stalled. An error run shows its single item.
// Stalls: once an end item waits in the hand-off register while the finisher
//   still works on the previous run, hold every input item until the finisher
//   goes idle. A stalled result holds the finisher through the output register.
// Reset: rst_n synchronous, active low; polymod state returns to 1.
module output_descriptor_checksum_core
  import odc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  odc_in_if.sink    in_ch,
  odc_out_if.source out_ch
);

  // End-of-string work travels as one struct between the two halves.
  logic     job_valid;
  logic     job_ready;
  odc_job_t job;

  // Absorb characters: lookup, low 5 bits into the polymod, class symbol
  // every third character. Reset the run state after an end item.
  odc_absorb u_absorb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  // Finish the run: flush, eight zero symbols, XOR 1, then emit eight
  // characters through the output register, or one error item.
  odc_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .out_ch    (out_ch)
  );

endmodule

[design/odc_absorb.sv]
// Character absorber: charset lookup, polymod update and class gathering.
// Depends on odc_pkg and odc_in_if; hands end-of-string work to odc_finish.
module odc_absorb
  import odc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  odc_in_if.sink   in_ch,
  output logic     job_valid,
  output odc_job_t job,
  input  logic     job_ready
);

  logic [39:0] poly_r, poly_nxt;
  logic [4:0]  accum_r, accum_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        bad_r, bad_nxt;
  logic        job_valid_r, job_valid_nxt;
  odc_job_t    job_r, job_nxt;

  logic        accept;
  logic [7:0]  entry;
  logic        use_char;
  logic [39:0] poly_a;
  logic [6:0]  accum_wide;
  logic [39:0] poly_u;
  logic [4:0]  accum_u;
  logic [1:0]  count_u;
  logic        bad_u;

  assign in_ch.ready = !job_valid_r || job_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign entry       = IN_LUT[in_ch.char_code];
  assign use_char    = in_ch.has_char && !bad_r && entry[7];
  assign poly_a      = poly_step(poly_r, entry[4:0]);
  assign accum_wide  = {2'b00, accum_r} * 7'd3 + {5'b00000, entry[6:5]};

  always_comb begin
    poly_u  = poly_r;
    accum_u = accum_r;
    count_u = count_r;
    bad_u   = bad_r | (in_ch.has_char & !entry[7]);
    if (use_char) begin
      if (count_r == 2'd2) begin
        poly_u  = poly_step(poly_a, accum_wide[4:0]);
        accum_u = '0;
        count_u = '0;
      end else begin
        poly_u  = poly_a;
        accum_u = accum_wide[4:0];
        count_u = count_r + 2'd1;
      end
    end
  end

  always_comb begin
    poly_nxt      = poly_r;
    accum_nxt     = accum_r;
    count_nxt     = count_r;
    bad_nxt       = bad_r;
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r && !job_ready;
    if (accept) begin
      if (in_ch.end_of_string) begin
        // Hand the run over, then restart from the reset state.
        job_nxt.poly  = poly_u;
        job_nxt.accum = accum_u;
        job_nxt.flush = (count_u != 2'd0);
        job_nxt.bad   = bad_u;
        job_valid_nxt = 1'b1;
        poly_nxt      = 40'd1;
        accum_nxt     = '0;
        count_nxt     = '0;
        bad_nxt       = 1'b0;
      end else begin
        poly_nxt  = poly_u;
        accum_nxt = accum_u;
        count_nxt = count_u;
        bad_nxt   = bad_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= 40'd1;
      accum_r     <= '0;
      count_r     <= '0;
      bad_r       <= 1'b0;
      job_valid_r <= 1'b0;
    end else begin
      poly_r      <= poly_nxt;
      accum_r     <= accum_nxt;
      count_r     <= count_nxt;
      bad_r       <= bad_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

[design/odc_finish.sv]
// Finisher: class flush, eight zero steps, final XOR and checksum output.
// Depends on odc_pkg and odc_out_if; fed by odc_absorb.
module odc_finish
  import odc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  input  odc_job_t job,
  output logic     job_ready,
  odc_out_if.source out_ch
);

  fin_state_t  state_r, state_nxt;
  logic [39:0] poly_r, poly_nxt;
  logic [4:0]  accum_r, accum_nxt;
  logic        bad_r, bad_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_status_r, out_status_nxt;
  logic        out_final_r, out_final_nxt;
  logic        slot_free;

  assign job_ready = (state_r == FIN_IDLE);
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    poly_nxt       = poly_r;
    accum_nxt      = accum_r;
    bad_nxt        = bad_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_char_nxt   = out_char_r;
    out_status_nxt = out_status_r;
    out_final_nxt  = out_final_r;
    case (state_r)
      FIN_IDLE: begin
        if (job_valid) begin
          poly_nxt  = job.poly;
          accum_nxt = job.accum;
          bad_nxt   = job.bad;
          cnt_nxt   = '0;
          if (job.bad)        state_nxt = FIN_EMIT;
          else if (job.flush) state_nxt = FIN_FLUSH;
          else                state_nxt = FIN_ZERO;
        end
      end
      FIN_FLUSH: begin
        poly_nxt  = poly_step(poly_r, accum_r);
        state_nxt = FIN_ZERO;
      end
      FIN_ZERO: begin
        poly_nxt = poly_step(poly_r, 5'd0);
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == 3'(SYM_COUNT - 1)) begin
          poly_nxt  = poly_step(poly_r, 5'd0) ^ 40'd1;
          state_nxt = FIN_EMIT;
        end
      end
      FIN_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (bad_r) begin
            out_char_nxt   = 8'd0;
            out_status_nxt = 1'b1;
            out_final_nxt  = 1'b1;
            state_nxt      = FIN_IDLE;
          end else begin
            out_char_nxt   = out_char(poly_r[39:35]);
            out_status_nxt = 1'b0;
            out_final_nxt  = (cnt_r == 3'(SYM_COUNT - 1));
            poly_nxt       = {poly_r[34:0], 5'd0};
            cnt_nxt        = cnt_r + 3'd1;
            if (cnt_r == 3'(SYM_COUNT - 1)) state_nxt = FIN_IDLE;
          end
        end
      end
      default: state_nxt = FIN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FIN_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    poly_r       <= poly_nxt;
    accum_r      <= accum_nxt;
    bad_r        <= bad_nxt;
    out_char_r   <= out_char_nxt;
    out_status_r <= out_status_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.checksum_char = out_char_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.final_char    = out_final_r;

endmodule

[design/odc_checker.sv]
// Port-level checker for the descriptor checksum core, bound to the top level.
// Depends on output_descriptor_checksum_core_assert.svh.
`include "output_descriptor_checksum_core_assert.svh"

module odc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_status,
  input logic       out_final
);

  logic [9:0] out_word;

  assign out_word = {out_char, out_status, out_final};

  // Hold a stalled result.
  `ODC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ODC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_word))
  // An error run is a single item with a zero character.
  `ODC_ASSERT_NOW(a_err_single, clk, rst_n, out_valid && out_status, out_final && (out_char == 8'd0))
  // A good checksum character is a nonzero byte with bit 7 clear.
  `ODC_ASSERT_NOW(a_ok_char, clk, rst_n, out_valid && !out_status, out_char != 8'd0 && !out_char[7])

endmodule

bind output_descriptor_checksum_core odc_checker u_odc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_char   (out_ch.checksum_char),
  .out_status (out_ch.status),
  .out_final  (out_ch.final_char)
);
